[hdl/assert_macros.svh]
// Assertion helpers shared by the blitter modules.
// Every assertion samples on clk and is switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge.
`define SBCSF_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("sbcsf assertion failed");

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define SBCSF_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbcsf assertion failed");

`endif

[hdl/sbcsf_pkg.sv]
package sbcsf_pkg;

    localparam int MAX_SCREEN_DIM = 2048;
    localparam int MAX_SPRITE_DIM = 256;
    localparam int MAX_SCALE      = 8;

    // Field widths of the ports.
    localparam int COL_W      = 8;
    localparam int RGBA_W     = 32;
    localparam int ADDR_W     = 22;
    localparam int RGB_W      = 24;
    localparam int ALPHA_W    = RGBA_W - RGB_W;
    localparam int DEST_W     = 13;
    localparam int SCR_W      = 12;
    localparam int SPR_W      = 9;
    localparam int MODE_W     = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Internal widths.
    localparam int SCALE_W = $clog2(MAX_SCALE + 1);
    localparam int PROD_W  = SPR_W + SCALE_W;
    localparam int CRD_W   = DEST_W + 3;
    localparam int POS_W   = $clog2(MAX_SCREEN_DIM);
    localparam int END_W   = $clog2(MAX_SCREEN_DIM + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Bit positions inside draw_mode.
    localparam int MODE_FLIP_X = 0;
    localparam int MODE_FLIP_Y = 1;
    localparam int MODE_SCALE_LSB = 2;
    localparam int MODE_SCALE_MSB = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEST_X,
        REG_DEST_Y,
        REG_SCREEN_WIDTH,
        REG_SCREEN_HEIGHT,
        REG_SPRITE_WIDTH,
        REG_SPRITE_HEIGHT,
        REG_DRAW_MODE,
        REG_KEY_RGB
    } reg_index_t;

    typedef struct packed {
        logic signed [DEST_W-1:0] dest_x;
        logic signed [DEST_W-1:0] dest_y;
        logic [SCR_W-1:0]         screen_width;
        logic [SCR_W-1:0]         screen_height;
        logic [SPR_W-1:0]         sprite_width;
        logic [SPR_W-1:0]         sprite_height;
        logic [MODE_W-1:0]        draw_mode;
        logic [RGB_W-1:0]         key_rgb;
    } cfg_t;

    // One clipped block on the screen: columns x0..x1-1, rows y0..y1-1.
    typedef struct packed {
        logic [POS_W-1:0] x0;
        logic [END_W-1:0] x1;
        logic [POS_W-1:0] y0;
        logic [END_W-1:0] y1;
        logic [RGB_W-1:0] rgb;
    } blk_t;

    typedef struct packed {
        logic valid;
        blk_t blk;
    } push_t;

    typedef struct packed {
        logic avail;
        blk_t blk;
    } q_head_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } back_state_t;

    function automatic logic [SCR_W-1:0] sat_screen(input logic [SCR_W-1:0] v);
        return (v > SCR_W'(MAX_SCREEN_DIM)) ? SCR_W'(MAX_SCREEN_DIM) : v;
    endfunction

    function automatic logic [SPR_W-1:0] sat_sprite(input logic [SPR_W-1:0] v);
        return (v > SPR_W'(MAX_SPRITE_DIM)) ? SPR_W'(MAX_SPRITE_DIM) : v;
    endfunction

    function automatic logic [SCALE_W-1:0] scale_of(input logic [MODE_W-1:0] mode);
        logic [SCALE_W-1:0] s;
        s = SCALE_W'(mode[MODE_SCALE_MSB:MODE_SCALE_LSB]) + SCALE_W'(1);
        return (s > SCALE_W'(MAX_SCALE)) ? SCALE_W'(MAX_SCALE) : s;
    endfunction

endpackage

[hdl/sbcsf_if.sv]
interface sbcsf_pix_if;
    logic                              valid;
    logic                              ready;
    logic [sbcsf_pkg::COL_W-1:0]       src_col;
    logic [sbcsf_pkg::COL_W-1:0]       src_row;
    logic [sbcsf_pkg::RGBA_W-1:0]      pixel_rgba;

    modport source (output valid, output src_col, output src_row, output pixel_rgba,
                    input ready);
    modport sink   (input valid, input src_col, input src_row, input pixel_rgba,
                    output ready);
endinterface

interface sbcsf_wr_if;
    logic                              valid;
    logic                              ready;
    logic [sbcsf_pkg::ADDR_W-1:0]      write_addr;
    logic [sbcsf_pkg::RGB_W-1:0]       write_rgb;
    logic                              write_last;

    modport source (output valid, output write_addr, output write_rgb, output write_last,
                    input ready);
    modport sink   (input valid, input write_addr, input write_rgb, input write_last,
                    output ready);
endinterface

[hdl/sbcsf_front.sv]
module sbcsf_front (
    sbcsf_pix_if.sink        pixel,
    input  sbcsf_pkg::cfg_t  cfg,
    input  logic             q_full,
    output sbcsf_pkg::push_t push
);
    import sbcsf_pkg::*;

    logic [SPR_W-1:0]        sw;
    logic [SPR_W-1:0]        sh;
    logic [SCR_W-1:0]        scrw;
    logic [SCR_W-1:0]        scrh;
    logic [SCALE_W-1:0]      scale;
    logic                    transparent;
    logic                    outside;
    logic [SPR_W-1:0]        dx;
    logic [SPR_W-1:0]        dy;
    logic [PROD_W-1:0]       px;
    logic [PROD_W-1:0]       py;
    logic signed [CRD_W-1:0] x0s, x1s, y0s, y1s;
    logic signed [CRD_W-1:0] x0c, x1c, y0c, y1c;
    logic signed [CRD_W-1:0] scale_s, scrw_s, scrh_s;
    logic                    empty_blk;

    assign pixel.ready = !q_full;

    always_comb
    begin
        sw    = sat_sprite(cfg.sprite_width);
        sh    = sat_sprite(cfg.sprite_height);
        scrw  = sat_screen(cfg.screen_width);
        scrh  = sat_screen(cfg.screen_height);
        scale = scale_of(cfg.draw_mode);

        transparent = (pixel.pixel_rgba[RGBA_W-1:ALPHA_W] == cfg.key_rgb)
                   || (pixel.pixel_rgba[ALPHA_W-1:0] == '0);
        outside     = (SPR_W'(pixel.src_col) >= sw) || (SPR_W'(pixel.src_row) >= sh);

        // Mirroring only matters for pixels inside the sprite, where it stays in range.
        dx = cfg.draw_mode[MODE_FLIP_X] ? (sw - SPR_W'(1) - SPR_W'(pixel.src_col))
                                        : SPR_W'(pixel.src_col);
        dy = cfg.draw_mode[MODE_FLIP_Y] ? (sh - SPR_W'(1) - SPR_W'(pixel.src_row))
                                        : SPR_W'(pixel.src_row);

        px = PROD_W'(dx) * PROD_W'(scale);
        py = PROD_W'(dy) * PROD_W'(scale);

        scale_s = $signed(CRD_W'(scale));
        scrw_s  = $signed(CRD_W'(scrw));
        scrh_s  = $signed(CRD_W'(scrh));

        x0s = CRD_W'(cfg.dest_x) + $signed(CRD_W'(px));
        y0s = CRD_W'(cfg.dest_y) + $signed(CRD_W'(py));
        x1s = x0s + scale_s;
        y1s = y0s + scale_s;

        x0c = (x0s < 0) ? '0 : x0s;
        y0c = (y0s < 0) ? '0 : y0s;
        x1c = (x1s > scrw_s) ? scrw_s : x1s;
        y1c = (y1s > scrh_s) ? scrh_s : y1s;

        empty_blk = (x0c >= x1c) || (y0c >= y1c);

        push.valid   = pixel.valid && !q_full && !transparent && !outside && !empty_blk;
        push.blk.x0  = x0c[POS_W-1:0];
        push.blk.x1  = x1c[END_W-1:0];
        push.blk.y0  = y0c[POS_W-1:0];
        push.blk.y1  = y1c[END_W-1:0];
        push.blk.rgb = pixel.pixel_rgba[RGBA_W-1:ALPHA_W];
    end

endmodule

[hdl/sbcsf_queue.sv]
`include "assert_macros.svh"

module sbcsf_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  sbcsf_pkg::push_t    push,
    input  logic                pop,
    output logic                full,
    output sbcsf_pkg::q_head_t  head
);
    import sbcsf_pkg::*;

    blk_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head.avail = (count_reg != '0);
    assign head.blk   = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head.avail;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + QPTR_W'(1);
        end
        if (push.valid && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !push.valid)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entry_reg[wr_ptr_reg] <= push.blk;
        end
    end

    `SBCSF_ASSERT_ALWAYS(a_count_bound, count_reg <= QCNT_W'(QUEUE_DEPTH))
    `SBCSF_ASSERT_IMPL(a_no_push_full, full, !push.valid)

endmodule

[hdl/sbcsf_back.sv]
`include "assert_macros.svh"

module sbcsf_back (
    input  logic               clk,
    input  logic               rst_n,
    input  sbcsf_pkg::cfg_t    cfg,
    input  sbcsf_pkg::q_head_t head,
    output logic               pop,
    sbcsf_wr_if.source         fb_write
);
    import sbcsf_pkg::*;

    back_state_t       state_reg, state_next;
    blk_t              cur_reg, cur_next;
    logic [POS_W-1:0]  bx_reg, bx_next;
    logic [POS_W-1:0]  by_reg, by_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic              out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0] out_addr_reg, out_addr_next;
    logic [RGB_W-1:0]  out_rgb_reg, out_rgb_next;
    logic              out_last_reg, out_last_next;
    logic [SCR_W-1:0]  scrw;
    logic              out_free;
    logic              row_end;
    logic              blk_end;
    logic              emit;

    assign fb_write.valid      = out_valid_reg;
    assign fb_write.write_addr = out_addr_reg;
    assign fb_write.write_rgb  = out_rgb_reg;
    assign fb_write.write_last = out_last_reg;

    assign scrw     = sat_screen(cfg.screen_width);
    assign out_free = !out_valid_reg || fb_write.ready;
    assign row_end  = (END_W'(bx_reg) + END_W'(1) == cur_reg.x1);
    assign blk_end  = row_end && (END_W'(by_reg) + END_W'(1) == cur_reg.y1);

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        bx_next        = bx_reg;
        by_next        = by_reg;
        base_next      = base_reg;
        out_addr_next  = out_addr_reg;
        out_rgb_next   = out_rgb_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !fb_write.ready;
        emit           = 1'b0;
        pop            = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                pop = head.avail;
            end
            BK_RUN:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (blk_end)
                    begin
                        pop        = head.avail;
                        state_next = BK_IDLE;
                    end
                end
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
            out_addr_next  = base_reg + ADDR_W'(bx_reg);
            out_rgb_next   = cur_reg.rgb;
            out_last_next  = blk_end;
            if (row_end)
            begin
                bx_next   = cur_reg.x0;
                by_next   = by_reg + POS_W'(1);
                base_next = base_reg + ADDR_W'(scrw);
            end
            else
            begin
                bx_next = bx_reg + POS_W'(1);
            end
        end

        // A block waiting in the queue follows the last write of the previous one without a gap.
        if (pop)
        begin
            state_next = BK_RUN;
            cur_next   = head.blk;
            bx_next    = head.blk.x0;
            by_next    = head.blk.y0;
            base_next  = ADDR_W'(head.blk.y0) * ADDR_W'(scrw);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        bx_reg       <= bx_next;
        by_reg       <= by_next;
        base_reg     <= base_next;
        out_addr_reg <= out_addr_next;
        out_rgb_reg  <= out_rgb_next;
        out_last_reg <= out_last_next;
    end

    `SBCSF_ASSERT_IMPL(a_walk_in_block, state_reg == BK_RUN,
        (END_W'(bx_reg) < cur_reg.x1) && (END_W'(by_reg) < cur_reg.y1))
    `SBCSF_ASSERT_IMPL(a_row_base, state_reg == BK_RUN,
        base_reg == ADDR_W'(by_reg) * ADDR_W'(scrw))

endmodule

[hdl/sprite_blit_colorkey_scale_flip_unit.sv]
// Color-keyed sprite blitter with mirroring and integer scaling.
// The pixel channel takes one sprite pixel per item (column, row, 0xRRGGBBAA).
// The fb_write channel gives one framebuffer write per item: linear address,
// 0xRRGGBB color and a last mark on the final write that a pixel causes.
// Keyed, zero-alpha, out-of-sprite and fully clipped pixels are accepted and
// give no writes. Registers are written through cfg_write_en/cfg_index/cfg_data;
// users must write them only while the block is idle; it does not enforce this.
// A pixel's writes pass the block queue, walker and output register in turn.
// Throughput: the walker emits one write per cycle unless the receiver stalls;
// a scale-s pixel gives up to s*s writes, and blocks follow one another with no gap.
// A two-entry block queue sits between the classifier and the walker, so new
// pixels are taken while the walker is still busy or the receiver stalls.
// When the receiver holds ready low the output register keeps its write and
// the walker waits; once the queue is full the pixel channel drops ready.
// Reset empties the queue and the output register and loads the register
// reset values (640x480 screen, 16x16 sprite, scale one, key 0xFF00FF).
module sprite_blit_colorkey_scale_flip_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_en,
    input  logic [sbcsf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sbcsf_pkg::CFG_DATA_W-1:0] cfg_data,
    sbcsf_pix_if.sink                        pixel,
    sbcsf_wr_if.source                       fb_write
);
    import sbcsf_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    push_t   push;
    q_head_t head;
    logic    q_full;
    logic    pop;

    // Register file. Every index has a register, so no write is ever dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_DEST_X:        cfg_next.dest_x        = $signed(cfg_data[DEST_W-1:0]);
                REG_DEST_Y:        cfg_next.dest_y        = $signed(cfg_data[DEST_W-1:0]);
                REG_SCREEN_WIDTH:  cfg_next.screen_width  = cfg_data[SCR_W-1:0];
                REG_SCREEN_HEIGHT: cfg_next.screen_height = cfg_data[SCR_W-1:0];
                REG_SPRITE_WIDTH:  cfg_next.sprite_width  = cfg_data[SPR_W-1:0];
                REG_SPRITE_HEIGHT: cfg_next.sprite_height = cfg_data[SPR_W-1:0];
                REG_DRAW_MODE:     cfg_next.draw_mode     = cfg_data[MODE_W-1:0];
                REG_KEY_RGB:       cfg_next.key_rgb       = cfg_data[RGB_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dest_x        <= '0;
            cfg_reg.dest_y        <= '0;
            cfg_reg.screen_width  <= SCR_W'(640);
            cfg_reg.screen_height <= SCR_W'(480);
            cfg_reg.sprite_width  <= SPR_W'(16);
            cfg_reg.sprite_height <= SPR_W'(16);
            cfg_reg.draw_mode     <= '0;
            cfg_reg.key_rgb       <= RGB_W'(24'hFF00FF);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: drops transparent and out-of-sprite pixels, mirrors, scales and clips to a block, dropping empty ones.
    sbcsf_front u_front (
        .pixel  (pixel),
        .cfg    (cfg_reg),
        .q_full (q_full),
        .push   (push)
    );

    // Short queue of clipped blocks between the two halves.
    sbcsf_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (q_full),
        .head  (head)
    );

    // Back: walks each block in row-major order, one write per cycle unless the receiver stalls.
    sbcsf_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .head     (head),
        .pop      (pop),
        .fb_write (fb_write)
    );

endmodule

[tb/sv/tb_sprite_blit_colorkey_scale_flip_unit.sv]
`timescale 1ns / 1ps

module tb_sprite_blit_colorkey_scale_flip_unit;

    import sbcsf_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 7;
    // A pixel's writes pass the block queue, the walker and the output register.
    // Dropped pixels never enter the queue; a few quiet cycles after the last
    // write still keep register writes well away from any traffic.
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_BURST     = 12;

    // One framebuffer write as the block presents it.
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [RGB_W-1:0]  rgb;
        logic              last;
    } fb_write_t;

    logic clk;
    logic rst_n;
    logic                  cfg_write_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    sbcsf_pix_if pixel_ch ();
    sbcsf_wr_if  fb_ch ();

    // Our own copy of the register file, updated at each register write.
    cfg_t blit_regs;

    // Framebuffer writes that the block still owes us, oldest first.
    fb_write_t expected_writes[$];

    int mismatch_count;
    int cycle_count;

    // Knobs that shape the traffic of the current phase.
    int burst_left;       // items left in the sender's current burst
    int gap_max;          // longest idle gap between bursts
    int stall_pct;        // chance per cycle that the receiver starts a stall
    int ready_hold_left;  // long hold-off of the receiver, in cycles

    sprite_blit_colorkey_scale_flip_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel        (pixel_ch),
        .fb_write     (fb_ch)
    );

    always
    begin
        clk = 1'b1;
        #CLK_HALF;
        clk = 1'b0;
        #CLK_HALF;
    end

    // ------------------------------------------------------------------
    // Blit predictor
    // ------------------------------------------------------------------

    function automatic cfg_t default_setting();
        cfg_t s;
        s.dest_x        = '0;
        s.dest_y        = '0;
        s.screen_width  = 12'd640;
        s.screen_height = 12'd480;
        s.sprite_width  = 9'd16;
        s.sprite_height = 9'd16;
        s.draw_mode     = '0;
        s.key_rgb       = 24'hFF00FF;
        return s;
    endfunction

    // Decodes one register write into the local register copy. Only the
    // low bits of the data that belong to the register are kept.
    function automatic void apply_reg_write(input reg_index_t idx,
                                            input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_DEST_X:        blit_regs.dest_x        = data[DEST_W-1:0];
            REG_DEST_Y:        blit_regs.dest_y        = data[DEST_W-1:0];
            REG_SCREEN_WIDTH:  blit_regs.screen_width  = data[SCR_W-1:0];
            REG_SCREEN_HEIGHT: blit_regs.screen_height = data[SCR_W-1:0];
            REG_SPRITE_WIDTH:  blit_regs.sprite_width  = data[SPR_W-1:0];
            REG_SPRITE_HEIGHT: blit_regs.sprite_height = data[SPR_W-1:0];
            REG_DRAW_MODE:     blit_regs.draw_mode     = data[MODE_W-1:0];
            REG_KEY_RGB:       blit_regs.key_rgb       = data[RGB_W-1:0];
            default: ;
        endcase
    endfunction

    // Works out every write that one accepted pixel causes and queues them
    // in row-major order, the final one carrying the last mark.
    function automatic void predict_writes(input logic [COL_W-1:0] col,
                                           input logic [COL_W-1:0] row,
                                           input logic [RGBA_W-1:0] rgba);
        int spr_w, spr_h, scr_w, scr_h, scale;
        int c, r, org_x, org_y, x0, y0, x1, y1;
        fb_write_t w;
        spr_w = (blit_regs.sprite_width > MAX_SPRITE_DIM) ? MAX_SPRITE_DIM
                                                          : blit_regs.sprite_width;
        spr_h = (blit_regs.sprite_height > MAX_SPRITE_DIM) ? MAX_SPRITE_DIM
                                                           : blit_regs.sprite_height;
        scr_w = (blit_regs.screen_width > MAX_SCREEN_DIM) ? MAX_SCREEN_DIM
                                                          : blit_regs.screen_width;
        scr_h = (blit_regs.screen_height > MAX_SCREEN_DIM) ? MAX_SCREEN_DIM
                                                           : blit_regs.screen_height;
        scale = int'(blit_regs.draw_mode[MODE_SCALE_MSB:MODE_SCALE_LSB]) + 1;
        if (scale > MAX_SCALE)
            scale = MAX_SCALE;
        c = int'(col);
        r = int'(row);
        org_x = int'(blit_regs.dest_x);
        org_y = int'(blit_regs.dest_y);

        // Transparent: the color key matches or the alpha is zero.
        if (rgba[RGBA_W-1:ALPHA_W] == blit_regs.key_rgb || rgba[ALPHA_W-1:0] == '0)
            return;
        // Pixels outside the sprite are dropped; a zero size drops them all.
        if (c >= spr_w || r >= spr_h)
            return;

        if (blit_regs.draw_mode[MODE_FLIP_X])
            c = spr_w - 1 - c;
        if (blit_regs.draw_mode[MODE_FLIP_Y])
            r = spr_h - 1 - r;

        x0 = org_x + c * scale;
        y0 = org_y + r * scale;
        x1 = x0 + scale;
        y1 = y0 + scale;
        if (x0 < 0) x0 = 0;
        if (y0 < 0) y0 = 0;
        if (x1 > scr_w) x1 = scr_w;
        if (y1 > scr_h) y1 = scr_h;
        if (x0 >= x1 || y0 >= y1)
            return;

        for (int by = y0; by < y1; by++)
        begin
            for (int bx = x0; bx < x1; bx++)
            begin
                w.addr = ADDR_W'(by * scr_w + bx);
                w.rgb  = rgba[RGBA_W-1:ALPHA_W];
                w.last = (by == y1 - 1) && (bx == x1 - 1);
                expected_writes.push_back(w);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------

    // Leaves the write enable high; load_regs lowers it after the last write
    // so that back-to-back writes never drop and raise it in one step.
    task automatic put_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(posedge clk);
        apply_reg_write(idx, data);
    endtask

    // Writes all eight registers. Unused upper data bits carry noise, which
    // the block must ignore.
    task automatic load_regs(input cfg_t s);
        logic [CFG_DATA_W-1:0] noise;
        noise = CFG_DATA_W'($urandom);
        put_reg(REG_DEST_X,        {noise[23:13], s.dest_x});
        put_reg(REG_DEST_Y,        {noise[23:13], s.dest_y});
        put_reg(REG_SCREEN_WIDTH,  {noise[23:12], s.screen_width});
        put_reg(REG_SCREEN_HEIGHT, {noise[23:12], s.screen_height});
        put_reg(REG_SPRITE_WIDTH,  {noise[23:9],  s.sprite_width});
        put_reg(REG_SPRITE_HEIGHT, {noise[23:9],  s.sprite_height});
        put_reg(REG_DRAW_MODE,     {noise[23:5],  s.draw_mode});
        put_reg(REG_KEY_RGB,       s.key_rgb);
        cfg_write_en <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Pixel sender
    // ------------------------------------------------------------------

    // Offers one pixel item and returns once it has been taken. Items go out
    // in bursts of random length; between bursts valid drops for a random
    // gap. Valid stays high from one item to the next within a burst.
    task automatic send_pixel(input logic [COL_W-1:0] col,
                              input logic [COL_W-1:0] row,
                              input logic [RGBA_W-1:0] rgba);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(gap_max, 0);
            if (gap > 0)
            begin
                pixel_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(MAX_BURST, 1);
        end
        pixel_ch.valid      <= 1'b1;
        pixel_ch.src_col    <= col;
        pixel_ch.src_row    <= row;
        pixel_ch.pixel_rgba <= rgba;
        do
            @(posedge clk);
        while (!pixel_ch.ready);
        predict_writes(col, row, rgba);
        burst_left--;
    endtask

    // Stops offering pixels and waits until every expected write has come,
    // then leaves a few quiet cycles.
    task automatic wait_drain();
        pixel_ch.valid <= 1'b0;
        burst_left = 0;
        while (expected_writes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly well-formed pixels: inside the sprite, opaque, now and then in
    // the key color. The rest is noise over the full field ranges.
    task automatic send_random_pixel();
        int spr_w, spr_h;
        logic [COL_W-1:0]  col, row;
        logic [RGBA_W-1:0] rgba;
        spr_w = (blit_regs.sprite_width > MAX_SPRITE_DIM) ? MAX_SPRITE_DIM
                                                          : blit_regs.sprite_width;
        spr_h = (blit_regs.sprite_height > MAX_SPRITE_DIM) ? MAX_SPRITE_DIM
                                                           : blit_regs.sprite_height;
        rgba = $urandom;
        if ($urandom_range(99) < 85 && spr_w > 0 && spr_h > 0)
        begin
            col = COL_W'($urandom_range(spr_w - 1));
            row = COL_W'($urandom_range(spr_h - 1));
            if (rgba[ALPHA_W-1:0] == '0)
                rgba[0] = 1'b1;
            if ($urandom_range(9) == 0)
                rgba[RGBA_W-1:ALPHA_W] = blit_regs.key_rgb;
        end
        else
        begin
            col = COL_W'($urandom);
            row = COL_W'($urandom);
            if ($urandom_range(3) == 0)
                rgba[ALPHA_W-1:0] = '0;
        end
        send_pixel(col, row, rgba);
    endtask

    // ------------------------------------------------------------------
    // Write receiver and checker
    // ------------------------------------------------------------------

    // Ready follows a stall pattern of its own: short random stall runs,
    // plus the long hold-off that the back-pressure test asks for.
    initial
    begin
        int stall_run;
        stall_run = 0;
        fb_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (ready_hold_left > 0)
            begin
                ready_hold_left--;
                fb_ch.ready <= 1'b0;
            end
            else if (stall_run > 0)
            begin
                stall_run--;
                fb_ch.ready <= 1'b0;
            end
            else if ($urandom_range(99) < stall_pct)
            begin
                stall_run = $urandom_range(6, 0);
                fb_ch.ready <= 1'b0;
            end
            else
                fb_ch.ready <= 1'b1;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // Each write taken from the block is compared with the oldest one owed.
    always @(posedge clk)
    begin
        fb_write_t want;
        if (rst_n && fb_ch.valid && fb_ch.ready)
        begin
            if (expected_writes.size() == 0)
                report_mismatch($sformatf("unexpected write addr=%0d rgb=%06h last=%0b",
                                          fb_ch.write_addr, fb_ch.write_rgb,
                                          fb_ch.write_last));
            else
            begin
                want = expected_writes.pop_front();
                if (fb_ch.write_addr !== want.addr)
                    report_mismatch($sformatf("write_addr %0d, expected %0d",
                                              fb_ch.write_addr, want.addr));
                if (fb_ch.write_rgb !== want.rgb)
                    report_mismatch($sformatf("write_rgb %06h, expected %06h at addr %0d",
                                              fb_ch.write_rgb, want.rgb, want.addr));
                if (fb_ch.write_last !== want.last)
                    report_mismatch($sformatf("write_last %0b, expected %0b at addr %0d",
                                              fb_ch.write_last, want.last, want.addr));
            end
        end
    end

    // Watchdog: a hung handshake or missing writes end the run here.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Register reset values: 640x480 screen, 16x16 sprite, scale one,
    // key 0xFF00FF. Covers opaque, keyed, zero-alpha and out-of-sprite pixels.
    task automatic test_reset_defaults();
        gap_max   = 2;
        stall_pct = 20;
        send_pixel(8'd0,  8'd0,  32'h123456FF);
        send_pixel(8'd15, 8'd15, 32'hABCDEF01);
        send_pixel(8'd3,  8'd2,  32'hFF00FF80);
        send_pixel(8'd3,  8'd2,  32'h12345600);
        send_pixel(8'd16, 8'd0,  32'h0000FFFF);
        send_pixel(8'd0,  8'd16, 32'h0000FFFF);
        wait_drain();
    endtask

    // Both flips at scale eight with the origin off the top-left corner:
    // one block is clipped to a corner, one lands whole.
    task automatic test_flip_scale_clip();
        cfg_t s;
        s = default_setting();
        s.dest_x    = -13'sd4;
        s.dest_y    = -13'sd4;
        s.draw_mode = 5'b11111;
        load_regs(s);
        send_pixel(8'd15,  8'd15,  32'h55AA33C0);
        send_pixel(8'd0,   8'd0,   32'hA5A5A5FF);
        send_pixel(8'd255, 8'd255, 32'h0F0F0F7F);
        wait_drain();
    endtask

    // Saturation of oversized screen and sprite sizes, the top address,
    // zero sizes and a one-pixel screen.
    task automatic test_screen_and_sprite_limits();
        cfg_t s;
        s = default_setting();
        s.screen_width  = 12'hFFF;
        s.screen_height = 12'hFFF;
        s.sprite_width  = 9'd256;
        s.sprite_height = 9'd256;
        s.draw_mode     = 5'b11100;
        s.dest_x        = 13'sd2040;
        s.dest_y        = 13'sd2040;
        load_regs(s);
        send_pixel(8'd0, 8'd0, 32'hFFFFFFFF);   // reaches the last address
        send_pixel(8'd1, 8'd0, 32'h010203FF);   // starts past the right edge
        wait_drain();

        s.sprite_width  = 9'h1FF;
        s.sprite_height = 9'h1FF;
        s.draw_mode     = 5'b00011;
        s.dest_x        = '0;
        s.dest_y        = '0;
        load_regs(s);
        send_pixel(8'd255, 8'd255, 32'h808080FF);
        send_pixel(8'd0,   8'd0,   32'h7F7F7F01);
        wait_drain();

        s.screen_width = '0;
        load_regs(s);
        send_pixel(8'd0, 8'd0, 32'h112233FF);
        wait_drain();

        s.screen_width  = 12'd1;
        s.screen_height = 12'd1;
        load_regs(s);
        send_pixel(8'd255, 8'd255, 32'h445566FF);
        send_pixel(8'd254, 8'd255, 32'h445566FF);
        wait_drain();

        s = default_setting();
        s.sprite_width = '0;
        load_regs(s);
        send_pixel(8'd0, 8'd0, 32'h778899FF);
        wait_drain();
    endtask

    // Color keys at both ends, and origins at the extremes of their range.
    task automatic test_color_key_limits();
        cfg_t s;
        s = default_setting();
        s.key_rgb = '0;
        load_regs(s);
        send_pixel(8'd0, 8'd0, 32'h000000FF);
        send_pixel(8'd0, 8'd0, 32'h000001FF);
        wait_drain();

        s.key_rgb = 24'hFFFFFF;
        load_regs(s);
        send_pixel(8'd1, 8'd0, 32'hFFFFFFFF);
        send_pixel(8'd1, 8'd0, 32'hFFFFFE01);
        wait_drain();

        s.dest_x = -13'sd4096;
        s.dest_y = 13'sd4095;
        load_regs(s);
        send_pixel(8'd0, 8'd0, 32'h123456FF);
        wait_drain();

        s.dest_x = 13'sd4095;
        s.dest_y = -13'sd4096;
        load_regs(s);
        send_pixel(8'd15, 8'd15, 32'h123456FF);
        wait_drain();
    endtask

    function automatic logic [SCR_W-1:0] pick_screen_dim();
        case ($urandom_range(19))
            0:       return '0;
            1:       return SCR_W'($urandom_range(4, 1));
            2:       return SCR_W'($urandom_range(4095, 2048));
            default: return SCR_W'($urandom_range(128, 16));
        endcase
    endfunction

    function automatic logic [SPR_W-1:0] pick_sprite_dim();
        case ($urandom_range(9))
            0:       return '0;
            1:       return SPR_W'($urandom_range(511, 200));
            default: return SPR_W'($urandom_range(16, 1));
        endcase
    endfunction

    // Random setting whose origin mostly lets part of the sprite land on
    // screen, so that most pixels cause writes.
    function automatic cfg_t random_setting();
        cfg_t s;
        int scale, spr_w, spr_h, scr_w, scr_h, org;
        s.draw_mode     = MODE_W'($urandom);
        s.screen_width  = pick_screen_dim();
        s.screen_height = pick_screen_dim();
        s.sprite_width  = pick_sprite_dim();
        s.sprite_height = pick_sprite_dim();
        s.key_rgb       = RGB_W'($urandom);
        scale = int'(s.draw_mode[MODE_SCALE_MSB:MODE_SCALE_LSB]) + 1;
        spr_w = (s.sprite_width > MAX_SPRITE_DIM) ? MAX_SPRITE_DIM : s.sprite_width;
        spr_h = (s.sprite_height > MAX_SPRITE_DIM) ? MAX_SPRITE_DIM : s.sprite_height;
        scr_w = (s.screen_width > MAX_SCREEN_DIM) ? MAX_SCREEN_DIM : s.screen_width;
        scr_h = (s.screen_height > MAX_SCREEN_DIM) ? MAX_SCREEN_DIM : s.screen_height;
        if ($urandom_range(9) == 0)
            s.dest_x = DEST_W'($urandom);
        else
        begin
            org = $urandom_range(spr_w * scale + scr_w, 0) - spr_w * scale;
            s.dest_x = DEST_W'((org > 4095) ? 4095 : org);
        end
        if ($urandom_range(9) == 0)
            s.dest_y = DEST_W'($urandom);
        else
        begin
            org = $urandom_range(spr_h * scale + scr_h, 0) - spr_h * scale;
            s.dest_y = DEST_W'((org > 4095) ? 4095 : org);
        end
        return s;
    endfunction

    // Several phases, each with a new register setting and its own
    // sender and receiver idling.
    task automatic test_random_blits();
        repeat (8)
        begin
            load_regs(random_setting());
            case ($urandom_range(2))
                0:       gap_max = 0;
                1:       gap_max = 3;
                default: gap_max = 8;
            endcase
            case ($urandom_range(2))
                0:       stall_pct = 0;
                1:       stall_pct = 20;
                default: stall_pct = 50;
            endcase
            repeat (9) send_random_pixel();
            wait_drain();
        end
    endtask

    // The receiver holds off for a long stretch while pixels keep coming at
    // scale two, so the block queue fills and the pixel channel stalls.
    task automatic test_output_backpressure();
        cfg_t s;
        s = default_setting();
        s.draw_mode = 5'b00100;
        load_regs(s);
        gap_max   = 0;
        stall_pct = 0;
        ready_hold_left = 300;
        repeat (20)
            send_pixel(COL_W'($urandom_range(15)), COL_W'($urandom_range(15)),
                       $urandom | 32'h1);
        wait_drain();
    endtask

    // No idling on either side at scale one: one write per cycle.
    task automatic test_full_rate();
        load_regs(default_setting());
        gap_max   = 0;
        stall_pct = 0;
        repeat (15) send_random_pixel();
        wait_drain();
    endtask

    initial
    begin
        rst_n               <= 1'b0;
        cfg_write_en        <= 1'b0;
        cfg_index           <= REG_DEST_X;
        cfg_data            <= '0;
        pixel_ch.valid      <= 1'b0;
        pixel_ch.src_col    <= '0;
        pixel_ch.src_row    <= '0;
        pixel_ch.pixel_rgba <= '0;
        mismatch_count  = 0;
        burst_left      = 0;
        gap_max         = 0;
        stall_pct       = 0;
        ready_hold_left = 0;
        blit_regs       = default_setting();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_flip_scale_clip();
        test_screen_and_sprite_limits();
        test_color_key_limits();
        test_random_blits();
        test_output_backpressure();
        test_full_rate();

        if (mismatch_count == 0 && expected_writes.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/sbcsf_pkg.sv
hdl/sbcsf_if.sv
hdl/sbcsf_front.sv
hdl/sbcsf_queue.sv
hdl/sbcsf_back.sv
hdl/sprite_blit_colorkey_scale_flip_unit.sv
tb/sv/tb_sprite_blit_colorkey_scale_flip_unit.sv
